[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dfs_pkg.sv]
// Types and constants shared by the delimited field splitter modules.
`default_nettype none
package dfs_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [1:0] REG_DELIMITER  = 2'd0;
  localparam logic [1:0] REG_USE_QUOTES = 2'd1;
  localparam logic [1:0] REG_USE_PARENS = 2'd2;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       field_was_quoted;
    logic       record_done;
    logic       mismatch;
  } res_t;

  // Results of one input byte, in order; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } step_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic       use_quotes;
    logic       use_parens;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/dfs_core.sv]
// Parser state and per-byte field splitting logic.
`default_nettype none
module dfs_core
  import dfs_pkg::*;
#(
  parameter int PAREN_MAX = 255,
  parameter int DEPTH_W   = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       advance,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_record,
  output step_t           step
);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(PAREN_MAX);

  logic [7:0]         held_byte, held_byte_next;
  logic               held_valid, held_valid_next;
  logic               inside_quotes, inside_quotes_next;
  logic [DEPTH_W-1:0] paren_depth, paren_depth_next;
  logic               in_leading_spaces, in_leading_spaces_next;
  logic               quoted_field, quoted_field_next;

  logic is_crlf, is_quote, byte_res_valid;
  res_t byte_res, eor_res;

  assign is_crlf  = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
  assign is_quote = cfg.use_quotes && (data_byte == CHAR_QUOTE);

  always_comb begin
    held_byte_next         = held_byte;
    held_valid_next        = held_valid;
    inside_quotes_next     = inside_quotes;
    paren_depth_next       = paren_depth;
    in_leading_spaces_next = in_leading_spaces;
    quoted_field_next      = quoted_field;
    byte_res               = '0;
    byte_res_valid         = 1'b0;

    if (!is_crlf) begin
      if (is_quote) begin
        inside_quotes_next = !inside_quotes;
      end
      // Paren tracking sees the quote state after this byte's toggle.
      if (cfg.use_parens && data_byte == CHAR_OPEN && !inside_quotes_next) begin
        if (paren_depth != DEPTH_MAX) begin
          paren_depth_next = paren_depth + 1'b1;
        end
      end else if (cfg.use_parens && data_byte == CHAR_CLOSE && paren_depth != '0 &&
                   !inside_quotes_next) begin
        paren_depth_next = paren_depth - 1'b1;
      end

      priority if (data_byte == cfg.delimiter && paren_depth_next == '0 &&
                   !inside_quotes_next) begin
        byte_res_valid            = 1'b1;
        byte_res.field_end        = 1'b1;
        byte_res.field_was_quoted = quoted_field;
        held_byte_next            = '0;
        held_valid_next           = 1'b0;
        in_leading_spaces_next    = 1'b1;
        quoted_field_next         = 1'b0;
      end else if (in_leading_spaces && data_byte == CHAR_SPACE) begin
        // drop leading space
        in_leading_spaces_next = 1'b1;
      end else if (in_leading_spaces && is_quote) begin
        in_leading_spaces_next = 1'b0;
        quoted_field_next      = 1'b1;
      end else begin
        in_leading_spaces_next = 1'b0;
        if (quoted_field) begin
          // release the held byte, hold this one
          byte_res_valid      = held_valid;
          byte_res.out_byte   = held_byte;
          byte_res.byte_valid = held_valid;
          held_byte_next      = data_byte;
          held_valid_next     = 1'b1;
        end else begin
          byte_res_valid      = 1'b1;
          byte_res.out_byte   = data_byte;
          byte_res.byte_valid = 1'b1;
        end
      end
    end

    eor_res                  = '0;
    eor_res.field_end        = 1'b1;
    eor_res.field_was_quoted = quoted_field_next;
    eor_res.record_done      = 1'b1;
    eor_res.mismatch         = (cfg.use_quotes && inside_quotes_next) ||
                               (cfg.use_parens && paren_depth_next != '0);

    if (end_of_record) begin
      held_byte_next         = '0;
      held_valid_next        = 1'b0;
      inside_quotes_next     = 1'b0;
      paren_depth_next       = '0;
      in_leading_spaces_next = 1'b1;
      quoted_field_next      = 1'b0;
    end

    step.count  = {1'b0, byte_res_valid} + {1'b0, end_of_record};
    step.first  = byte_res_valid ? byte_res : eor_res;
    step.second = eor_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte         <= '0;
      held_valid        <= 1'b0;
      inside_quotes     <= 1'b0;
      paren_depth       <= '0;
      in_leading_spaces <= 1'b1;
      quoted_field      <= 1'b0;
    end else if (advance) begin
      held_byte         <= held_byte_next;
      held_valid        <= held_valid_next;
      inside_quotes     <= inside_quotes_next;
      paren_depth       <= paren_depth_next;
      in_leading_spaces <= in_leading_spaces_next;
      quoted_field      <= quoted_field_next;
    end
  end

endmodule
`default_nettype wire

[rtl/dfs_out_queue.sv]
// Four-entry result queue: takes up to two results a cycle while room is high, issues one when out_ready is high.
`default_nettype none
module dfs_out_queue
  import dfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire step_t step,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  res_t       entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] push_n;
  logic       pop;

  assign push_n     = push ? step.count : 2'd0;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 3'd0);
  assign out_res    = entries[rd_ptr];
  // Always leave space for the worst case of two results per byte.
  assign room       = (count <= 3'd2);
  assign count_next = count + {1'b0, push_n} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push && push_n != 2'd0) begin
      entries[wr_ptr] <= step.first;
    end
    if (push && push_n == 2'd2) begin
      entries[wr_ptr + 2'd1] <= step.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

[rtl/delimited_field_splitter.sv]
// Top level of the delimited field splitter.
//
// Input stream: one record byte per transaction on s_tdata; s_tlast marks
// the record's last byte. Output stream: one result per transaction, either
// a content byte (m_tuser[0]) or a field end (m_tuser[1]); m_tlast marks the
// record's final field end and m_tdata[9] flags open quotes or parens there.
// Configuration (delimiter, quote and paren enables) is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the stream is
// idle, which the block does not enforce. Each byte's results go into the
// four-entry result queue when its transaction is accepted. The slave side
// takes one byte per cycle while the queue has room; each byte makes 0 to 2
// results and the master side issues one per cycle while m_tready is high.
// Reset clears the parse state, empties the queue and loads the default
// configuration. When the receiver stalls the queue fills and s_tready
// drops once fewer than two entries are free; no result is lost.
`default_nettype none
module delimited_field_splitter
  import dfs_pkg::*;
#(
  parameter int PAREN_MAX = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_record
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] field_was_quoted, [9] mismatch
  output logic [1:0]       m_tuser,   // [0] byte_valid, [1] field_end
  output logic             m_tlast,   // record_done
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int DEPTH_W = $clog2(PAREN_MAX + 1);

  cfg_t  cfg;
  step_t step;
  res_t  out_res;
  logic  accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter  <= DELIMITER_RESET;
      cfg.use_quotes <= 1'b1;
      cfg.use_parens <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIMITER:  cfg.delimiter  <= cfg_data;
        REG_USE_QUOTES: cfg.use_quotes <= cfg_data[0];
        REG_USE_PARENS: cfg.use_parens <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dfs_core #(
    .PAREN_MAX (PAREN_MAX),
    .DEPTH_W   (DEPTH_W)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .advance       (accept),
    .data_byte     (s_tdata),
    .end_of_record (s_tlast),
    .step          (step)
  );

  dfs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .step      (step),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {6'b0, out_res.mismatch, out_res.field_was_quoted, out_res.out_byte};
  assign m_tuser = {out_res.field_end, out_res.byte_valid};
  assign m_tlast = out_res.record_done;

endmodule
`default_nettype wire

[rtl/dfs_checker.sv]
// Port-level checks for the delimited field splitter, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module dfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  `DFS_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped under stall")
  `DFS_ASSERT_RST(a_empty_after_reset, rst |=> !m_tvalid, "result issued right after reset")
  `DFS_ASSERT(a_record_end_issued, s_tvalid && s_tready && s_tlast |=> m_tvalid, "record end not queued")
  `DFS_ASSERT(a_done_is_field_end, m_tvalid && m_tlast |-> m_tuser[1] && !m_tuser[0], "record done on a byte")
  `DFS_ASSERT(a_byte_no_flags, m_tvalid && m_tuser[0] |-> m_tdata[9:8] == 2'b00 && !m_tuser[1], "flags on a byte")

endmodule

bind delimited_field_splitter dfs_checker u_dfs_checker (.*);
`default_nettype wire
